// ----- hw/rtl/sfg_pkg.sv -----
// Package with operation codes and channel seed states for the seeded Fibonacci generator.
package sfg_pkg;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_QUERY = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        SEED_NONE   = 2'd0,
        SEED_ONE    = 2'd1,
        SEED_TWO    = 2'd2,
        SEED_POISON = 2'd3
    } t_seed_state;

    localparam int TERM_W  = 64;
    localparam int INDEX_W = 31;
    localparam int CHAN_W  = 2;

    localparam logic [TERM_W-1:0]  TERM_ALL_ONES = {TERM_W{1'b1}};
    localparam logic [INDEX_W-1:0] INDEX_MAX     = {INDEX_W{1'b1}};

endpackage

// ----- hw/rtl/seeded_fibonacci_generator.sv -----
// Top level of the multi-channel seeded Fibonacci generator.
// Takes one request per cycle when the output is not stalled and delivers one result
// per request. A request is registered, then the addressed channel's terms, seed
// state and read index are updated while the result is loaded into the output
// register; the single 64-bit add and overflow check on the selected channel sit in
// that step. Requests to the same channel may follow each other in consecutive cycles.
// Channel numbers at or above the number of implemented channels touch no state and
// answer zero.
module seeded_fibonacci_generator #(
    parameter int CHANNELS = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_func,
    input  logic [sfg_pkg::CHAN_W-1:0]        i_channel,
    input  logic signed [sfg_pkg::TERM_W-1:0] i_seed_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [sfg_pkg::TERM_W-1:0] o_term_value,
    output logic [sfg_pkg::INDEX_W-1:0]       o_index_value,
    output logic                              o_accepted
);

    localparam int NCH = (CHANNELS < (1 << sfg_pkg::CHAN_W)) ? CHANNELS
                                                             : (1 << sfg_pkg::CHAN_W);
    localparam int IW  = (NCH > 1) ? $clog2(NCH) : 1;

    typedef logic [sfg_pkg::TERM_W-1:0]  t_term;
    typedef logic [sfg_pkg::INDEX_W-1:0] t_index;

    t_term                r_older [0:NCH-1];
    t_term                r_newer [0:NCH-1];
    sfg_pkg::t_seed_state r_state [0:NCH-1];
    t_index               r_count [0:NCH-1];
    t_term                n_older [0:NCH-1];
    t_term                n_newer [0:NCH-1];
    sfg_pkg::t_seed_state n_state [0:NCH-1];
    t_index               n_count [0:NCH-1];

    logic                      r_req_valid;
    sfg_pkg::t_func            r_func;
    logic [sfg_pkg::CHAN_W-1:0] r_chan;
    t_term                     r_seed;

    logic   r_out_valid;
    t_term  r_term;
    t_index r_index;
    logic   r_acc;

    t_term  n_term;
    t_index n_index;
    logic   n_acc;

    logic                 advance;
    logic                 in_load;
    logic                 in_range;
    logic [IW-1:0]        sel;
    t_term                cur_older;
    t_term                cur_newer;
    sfg_pkg::t_seed_state cur_state;
    t_index               cur_count;
    t_term                sum;
    logic                 overflow;
    logic                 seed_neg;

    assign advance    = !r_out_valid || !i_out_stall;
    assign in_load    = !r_req_valid || advance;
    assign o_in_stall = !in_load;

    assign in_range  = ({1'b0, r_chan} < (sfg_pkg::CHAN_W+1)'(NCH));
    assign sel       = IW'(r_chan);
    assign cur_older = r_older[sel];
    assign cur_newer = r_newer[sel];
    assign cur_state = r_state[sel];
    assign cur_count = r_count[sel];
    assign sum       = cur_older + cur_newer;
    assign overflow  = !cur_older[sfg_pkg::TERM_W-1] && !cur_newer[sfg_pkg::TERM_W-1]
                       && sum[sfg_pkg::TERM_W-1];
    assign seed_neg  = r_seed[sfg_pkg::TERM_W-1];

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            n_older[c] = r_older[c];
            n_newer[c] = r_newer[c];
            n_state[c] = r_state[c];
            n_count[c] = r_count[c];
        end
        n_term  = '0;
        n_index = '0;
        n_acc   = !(r_func == sfg_pkg::FUNC_WRITE && seed_neg);
        if (in_range) begin
            case (r_func)
                sfg_pkg::FUNC_READ: begin
                    if (cur_state == sfg_pkg::SEED_NONE || cur_state == sfg_pkg::SEED_ONE) begin
                        n_term = '0;
                    end else if (cur_state == sfg_pkg::SEED_POISON) begin
                        n_term = sfg_pkg::TERM_ALL_ONES;
                    end else if (cur_count == t_index'(0)) begin
                        n_term = cur_older;
                    end else if (cur_count == t_index'(1)) begin
                        n_term = cur_newer;
                    end else if (overflow) begin
                        n_term = sfg_pkg::TERM_ALL_ONES;
                    end else begin
                        n_term       = sum;
                        n_older[sel] = cur_newer;
                        n_newer[sel] = sum;
                    end
                    if (cur_count != sfg_pkg::INDEX_MAX) begin
                        n_count[sel] = cur_count + t_index'(1);
                    end
                end
                sfg_pkg::FUNC_WRITE: begin
                    if (seed_neg) begin
                        n_older[sel] = sfg_pkg::TERM_ALL_ONES;
                        n_newer[sel] = sfg_pkg::TERM_ALL_ONES;
                        n_state[sel] = sfg_pkg::SEED_POISON;
                    end else begin
                        if (cur_state == sfg_pkg::SEED_NONE) begin
                            n_state[sel] = sfg_pkg::SEED_ONE;
                        end else if (cur_state == sfg_pkg::SEED_ONE) begin
                            n_state[sel] = sfg_pkg::SEED_TWO;
                        end
                        n_older[sel] = cur_newer;
                        n_newer[sel] = r_seed;
                        n_count[sel] = '0;
                    end
                end
                sfg_pkg::FUNC_CLEAR: begin
                    n_older[sel] = '0;
                    n_newer[sel] = '0;
                    n_state[sel] = sfg_pkg::SEED_NONE;
                    n_count[sel] = '0;
                end
                default: begin
                    n_index = cur_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < NCH; c++) begin
                r_older[c] <= '0;
                r_newer[c] <= '0;
                r_state[c] <= sfg_pkg::SEED_NONE;
                r_count[c] <= '0;
            end
        end else begin
            if (in_load) begin
                r_req_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_req_valid;
                if (r_req_valid) begin
                    r_term  <= n_term;
                    r_index <= n_index;
                    r_acc   <= n_acc;
                    for (int c = 0; c < NCH; c++) begin
                        r_older[c] <= n_older[c];
                        r_newer[c] <= n_newer[c];
                        r_state[c] <= n_state[c];
                        r_count[c] <= n_count[c];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_func <= sfg_pkg::t_func'(i_func);
            r_chan <= i_channel;
            r_seed <= i_seed_value;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_term_value  = r_term;
    assign o_index_value = r_index;
    assign o_accepted    = r_acc;

endmodule
